// ===== rtl/core/clsf_pkg.sv =====
// Package for the calorimeter layer seed finder: sizes, hit and control types.
`default_nettype none
package clsf_pkg;

	localparam int MAX_HITS   = 64;
	localparam int NUM_LAYERS = 64;
	localparam int IDX_W      = $clog2(MAX_HITS);
	localparam int CNT_W      = $clog2(MAX_HITS + 1);
	localparam int X_W        = 10;
	localparam int Y_W        = 10;
	localparam int E_W        = 24;
	localparam int L_W        = 7;
	localparam int BL_W       = 6;
	localparam int RATIO_W    = 17;
	localparam int FRAC_W     = 16;
	localparam int CUT_W      = RATIO_W + E_W;
	localparam int DATA_W     = 56;

	typedef struct packed {
		logic [X_W-1:0] x;
		logic [Y_W-1:0] y;
		logic [E_W-1:0] e;
	} hit_t;

	typedef struct packed {
		hit_t             hit;
		logic             flag;
		logic [IDX_W-1:0] idx;
	} travel_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		hit_t             wr_hit;
		logic [CUT_W-1:0] cut;
		logic [CNT_W-1:0] count;
		logic             cand_en;
		logic             veto_load;
		logic             veto_step;
		logic             rank_load;
		logic             rank_step;
		logic [IDX_W-1:0] emit_rank;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		S_LOAD,
		S_MULT,
		S_CAND,
		S_VETO,
		S_RANK,
		S_EMIT
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/core/calorimeter_layer_seed_finder.sv =====
// Top level of the calorimeter layer seed finder: load, search and emit control.
`default_nettype none
// Hits of one layer stream in one beat per cycle and are written into a ring
// of MAX_HITS cells; hits with an out-of-range layer or beyond a full store are
// dropped, but their tlast still closes the layer. After the beat with tlast
// the block stops taking hits and runs the search: the threshold product
// seed_ratio*peak, then the candidate marks, then two passes around the
// cell ring (first the 3x3 veto by a stronger neighbor, then the ascending
// energy rank of each seed). Seeds then leave one beat per cycle while the
// output is taken, lowest energy first, ties in load order; a layer without
// seeds gives one beat with tuser (none_found) set.
// Write seed_ratio on the cfg channel only while the block is idle.
module calorimeter_layer_seed_finder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [clsf_pkg::RATIO_W-1:0]  cfg_data,    // seed_ratio
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// [9:0] cell_x, [19:10] cell_y, [43:20] hit_energy, [50:44] layer_index
	input  wire logic [clsf_pkg::DATA_W-1:0]   s_axis_tdata,
	input  wire logic                          s_axis_tlast, // last_hit
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// [9:0] seed_x, [19:10] seed_y, [43:20] seed_energy, [50:44] seed_layer
	output logic [clsf_pkg::DATA_W-1:0]        m_axis_tdata,
	output logic                               m_axis_tuser, // none_found
	output logic                               m_axis_tlast  // last_seed
);
	import clsf_pkg::*;

	state_t           state_q, state_d;
	logic [RATIO_W-1:0] ratio_q;
	logic [CNT_W-1:0] count_q;
	logic [E_W-1:0]   peak_q;
	logic [BL_W-1:0]  layer_q;
	logic [CUT_W-1:0] cut_q;
	logic [CNT_W-1:0] step_q;
	logic [CNT_W-1:0] nseed_q;
	logic [CNT_W-1:0] emit_q;

	logic [DATA_W-1:0] out_data_q;
	logic              out_valid_q, out_none_q, out_last_q;

	hit_t              in_hit;
	logic [L_W-1:0]    in_layer;
	logic              in_fire, in_store;
	logic              out_free, emit_fire, emit_last;
	cell_ctrl_t        ctrl;
	travel_t           travel [MAX_HITS];
	hit_t              sel_hit [MAX_HITS];
	logic [MAX_HITS-1:0] sel_match;
	hit_t              pick;

	always_comb begin
		in_hit.x = s_axis_tdata[X_W-1:0];
		in_hit.y = s_axis_tdata[X_W+Y_W-1:X_W];
		in_hit.e = s_axis_tdata[X_W+Y_W+E_W-1:X_W+Y_W];
		in_layer = s_axis_tdata[X_W+Y_W+E_W+L_W-1:X_W+Y_W+E_W];
		in_fire  = s_axis_tvalid & s_axis_tready;
		in_store = in_fire && (in_layer >= L_W'(1)) && (in_layer <= L_W'(NUM_LAYERS))
		           && (count_q < CNT_W'(MAX_HITS));
		out_free  = ~out_valid_q | m_axis_tready;
		emit_fire = (state_q == S_EMIT) & out_free;
		emit_last = (nseed_q == '0) || (emit_q == nseed_q - CNT_W'(1));
	end

	// Selected seed of the current rank; at most one cell matches.
	always_comb begin
		pick = '0;
		for (int i = 0; i < MAX_HITS; i++) begin
			pick = pick | (sel_match[i] ? sel_hit[i] : hit_t'('0));
		end
	end

	always_comb begin
		state_d        = state_q;
		s_axis_tready  = (state_q == S_LOAD);
		ctrl           = '0;
		ctrl.wr_en     = in_store;
		ctrl.wr_idx    = count_q[IDX_W-1:0];
		ctrl.wr_hit    = in_hit;
		ctrl.cut       = cut_q;
		ctrl.count     = count_q;
		ctrl.emit_rank = emit_q[IDX_W-1:0];
		case (state_q)
			S_LOAD: begin
				if (in_fire && s_axis_tlast) state_d = S_MULT;
			end
			S_MULT: state_d = S_CAND;
			S_CAND: begin
				ctrl.cand_en = 1'b1;
				state_d = S_VETO;
			end
			S_VETO: begin
				ctrl.veto_load = (step_q == '0);
				ctrl.veto_step = (step_q != '0);
				if (step_q == CNT_W'(MAX_HITS)) state_d = S_RANK;
			end
			S_RANK: begin
				ctrl.rank_load = (step_q == '0);
				ctrl.rank_step = (step_q != '0);
				if (step_q == CNT_W'(MAX_HITS)) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (emit_fire && emit_last) state_d = S_LOAD;
			end
			default: state_d = S_LOAD;
		endcase
	end

	// Ring of hit cells; each hands its traveling copy to the next.
	for (genvar g = 0; g < MAX_HITS; g++) begin : g_cell
		clsf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.my_idx    (IDX_W'(g)),
			.ctrl      (ctrl),
			.travel_in (travel[(g + MAX_HITS - 1) % MAX_HITS]),
			.travel_out(travel[g]),
			.sel_hit   (sel_hit[g]),
			.sel_match (sel_match[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			ratio_q     <= '0;
			count_q     <= '0;
			peak_q      <= '0;
			layer_q     <= '0;
			step_q      <= '0;
			nseed_q     <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) ratio_q <= cfg_data;
			if (in_store) begin
				count_q <= count_q + CNT_W'(1);
				if (in_hit.e > peak_q) peak_q <= in_hit.e;
				layer_q <= BL_W'(in_layer - L_W'(1));
			end
			// ring pass step counter, shared by both passes
			if ((state_q == S_VETO || state_q == S_RANK) && step_q != CNT_W'(MAX_HITS)) begin
				step_q <= step_q + CNT_W'(1);
			end else begin
				step_q <= '0;
			end
			// every seed leaves the last cell once per rank pass
			if (ctrl.rank_load) begin
				nseed_q <= '0;
			end else if (ctrl.rank_step && travel[MAX_HITS-1].flag) begin
				nseed_q <= nseed_q + CNT_W'(1);
			end
			if (out_free) out_valid_q <= emit_fire;
			if (emit_fire) begin
				if (emit_last) begin
					emit_q  <= '0;
					count_q <= '0;
					peak_q  <= '0;
					layer_q <= '0;
				end else begin
					emit_q <= emit_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MULT) cut_q <= CUT_W'(ratio_q) * CUT_W'(peak_q);
		if (emit_fire) begin
			out_last_q <= emit_last;
			out_none_q <= (nseed_q == '0);
			if (nseed_q == '0) begin
				out_data_q <= '0;
			end else begin
				out_data_q <= DATA_W'({L_W'(layer_q) + L_W'(1), pick.e, pick.y, pick.x});
			end
		end
	end

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_none_q;
	assign m_axis_tlast  = out_last_q;

	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("none_found beat without last");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_HITS))
		else $error("hit count beyond store");
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> $onehot0(sel_match))
		else $error("several cells share one rank");
	a_rank_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && nseed_q != '0 |-> $onehot(sel_match))
		else $error("no cell holds the current rank");

endmodule
`default_nettype wire

// ===== rtl/core/clsf_cell.sv =====
// One hit cell of the seed finder ring: holds a hit, checks passing hits.
`default_nettype none
module clsf_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [clsf_pkg::IDX_W-1:0] my_idx,
	input  wire clsf_pkg::cell_ctrl_t      ctrl,
	input  wire clsf_pkg::travel_t         travel_in,
	output clsf_pkg::travel_t              travel_out,
	output clsf_pkg::hit_t                 sel_hit,
	output logic                           sel_match
);
	import clsf_pkg::*;

	hit_t             hit_q;
	travel_t          travel_q;
	logic             cand_q;
	logic             veto_q;
	logic [IDX_W-1:0] rank_q;

	logic             seed;
	logic [X_W:0]     dx;
	logic [Y_W:0]     dy;
	logic             dx_ok, dy_ok, near;
	logic             beats_me;
	logic             below_me;

	always_comb begin
		seed  = cand_q & ~veto_q;
		dx    = (hit_q.x >= travel_q.hit.x) ? {1'b0, hit_q.x - travel_q.hit.x}
		                                    : {1'b0, travel_q.hit.x - hit_q.x};
		dy    = (hit_q.y >= travel_q.hit.y) ? {1'b0, hit_q.y - travel_q.hit.y}
		                                    : {1'b0, travel_q.hit.y - hit_q.y};
		dx_ok = (dx <= (X_W+1)'(1));
		dy_ok = (dy <= (Y_W+1)'(1));
		near  = dx_ok & dy_ok & ~((dx == '0) & (dy == '0));
		beats_me = travel_q.flag & (travel_q.hit.e > hit_q.e) & near;
		below_me = travel_q.flag & ((travel_q.hit.e < hit_q.e) |
		           ((travel_q.hit.e == hit_q.e) & (travel_q.idx < my_idx)));
		travel_out = travel_q;
		sel_hit    = hit_q;
		sel_match  = seed & (rank_q == ctrl.emit_rank);
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en && ctrl.wr_idx == my_idx) begin
			hit_q <= ctrl.wr_hit;
		end
		if (ctrl.veto_load) begin
			travel_q <= '{hit: hit_q, flag: cand_q, idx: my_idx};
		end else if (ctrl.rank_load) begin
			travel_q <= '{hit: hit_q, flag: seed, idx: my_idx};
		end else if (ctrl.veto_step || ctrl.rank_step) begin
			travel_q <= travel_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= 1'b0;
			veto_q <= 1'b0;
			rank_q <= '0;
		end else begin
			if (ctrl.cand_en) begin
				cand_q <= (CNT_W'(my_idx) < ctrl.count) &&
				          ({1'b0, hit_q.e, {FRAC_W{1'b0}}} >= ctrl.cut);
			end
			if (ctrl.veto_load) begin
				veto_q <= 1'b0;
			end else if (ctrl.veto_step && beats_me) begin
				veto_q <= 1'b1;
			end
			if (ctrl.rank_load) begin
				rank_q <= '0;
			end else if (ctrl.rank_step && below_me) begin
				rank_q <= rank_q + IDX_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== verif/calorimeter_layer_seed_finder_tb.sv =====
// Self-checking testbench for the calorimeter layer seed finder.
`timescale 1ns / 1ps
module calorimeter_layer_seed_finder_tb;
	import clsf_pkg::*;

	localparam int  LIMIT_CYCLES = 600000;
	localparam int  DRAIN_CYCLES = 2 * MAX_HITS + 20; // ring passes plus margin
	localparam int  HOLD_CYCLES  = 800;
	localparam int  RATIO_ONE    = 65536;
	localparam int  RATIO_MAX    = (1 << RATIO_W) - 1;

	// one expected seed beat
	typedef struct {
		logic [X_W-1:0] x;
		logic [Y_W-1:0] y;
		logic [E_W-1:0] e;
		logic [L_W-1:0] layer;
		logic           none;
		logic           last;
	} seed_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [RATIO_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata = '0;  // [9:0] x, [19:10] y, [43:20] e, [50:44] layer
	logic s_axis_tlast = 1'b0;             // last_hit
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [DATA_W-1:0] m_axis_tdata;       // [9:0] x, [19:10] y, [43:20] e, [50:44] layer
	logic m_axis_tuser;                    // none_found
	logic m_axis_tlast;                    // last_seed

	calorimeter_layer_seed_finder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	// predictor state: mirror of the open layer and the threshold register
	hit_t              open_hits[$];
	logic [E_W-1:0]    layer_peak;
	logic [BL_W-1:0]   layer_sel;
	logic [RATIO_W-1:0] ratio_q;
	seed_beat_t        seeds_due[$];

	int errors = 0;
	int hits_sent = 0;
	int layers_closed = 0;
	int beats_checked = 0;
	int empty_layers = 0;
	int cycles = 0;

	bit tx_idle_en = 1'b1;   // sender may insert gaps
	bit rx_idle_en = 1'b1;   // receiver may stall
	logic rx_ready = 1'b0;
	logic rx_hold = 1'b0;
	bit hold_go = 1'b0;

	assign m_axis_tready = rx_ready & ~rx_hold;

	// Search on a closed layer: threshold, stable ascending sort, 3x3 veto.
	function automatic void close_layer();
		logic [63:0] cut;
		int order[$];
		int k;
		int dx, dy;
		bit keep;
		seed_beat_t b;
		int found;
		cut = 64'(ratio_q) * 64'(layer_peak);
		foreach (open_hits[i]) begin
			if ((64'(open_hits[i].e) << 16) >= cut) begin
				k = order.size();
				while (k > 0 && open_hits[order[k-1]].e > open_hits[i].e)
					k--;
				order.insert(k, i);
			end
		end
		found = 0;
		foreach (order[i]) begin
			keep = 1'b1;
			foreach (order[j]) begin
				dx = int'(open_hits[order[i]].x) - int'(open_hits[order[j]].x);
				dy = int'(open_hits[order[i]].y) - int'(open_hits[order[j]].y);
				// stronger candidate in a different neighbor cell vetoes; same cell never
				if (open_hits[order[j]].e > open_hits[order[i]].e &&
				    dx >= -1 && dx <= 1 && dy >= -1 && dy <= 1 && !(dx == 0 && dy == 0))
					keep = 1'b0;
			end
			if (keep) begin
				b.x = open_hits[order[i]].x;
				b.y = open_hits[order[i]].y;
				b.e = open_hits[order[i]].e;
				b.layer = L_W'(layer_sel) + 7'd1;
				b.none = 1'b0;
				b.last = 1'b0;
				seeds_due.insert(seeds_due.size(), b);
				found++;
			end
		end
		if (found == 0) begin
			b = '{x: '0, y: '0, e: '0, layer: '0, none: 1'b1, last: 1'b1};
			seeds_due.insert(seeds_due.size(), b);
			empty_layers++;
		end else
			seeds_due[seeds_due.size()-1].last = 1'b1;
		open_hits.delete();
		layer_peak = '0;
		layer_sel = '0;
		layers_closed++;
	endfunction

	function automatic void absorb_hit(hit_t h, logic [L_W-1:0] lay, logic last);
		// out-of-range layers and hits past a full store are dropped
		if (lay >= 1 && lay <= NUM_LAYERS && open_hits.size() < MAX_HITS) begin
			open_hits.insert(open_hits.size(), h);
			if (h.e > layer_peak)
				layer_peak = h.e;
			layer_sel = BL_W'(lay - 7'd1);
		end
		if (last)
			close_layer();
	endfunction

	// Send one hit beat; valid stays high into the next call when no gap is drawn.
	task automatic send_hit(logic [X_W-1:0] x, logic [Y_W-1:0] y, logic [E_W-1:0] e,
	                        logic [L_W-1:0] lay, logic last);
		int gap;
		hit_t h;
		gap = tx_idle_en ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = {5'b0, lay, e, y, x};
		s_axis_tlast = last;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		h.x = x;
		h.y = y;
		h.e = e;
		absorb_hit(h, lay, last);
		hits_sent++;
		@(negedge clk);
	endtask

	task automatic stop_sending();
		s_axis_tvalid = 1'b0;
		s_axis_tlast = 1'b0;
	endtask

	// Waits out every expected beat plus the search latency, then writes the ratio.
	task automatic write_ratio(logic [RATIO_W-1:0] r);
		stop_sending();
		wait (seeds_due.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_data = r;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		ratio_q = r;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Energy mix: full range, tiny values for ties, small values, values near full scale.
	function automatic logic [E_W-1:0] pick_energy();
		case ($urandom_range(0, 3))
			0: return E_W'($urandom);
			1: return E_W'($urandom_range(0, 7));
			2: return 24'hFFFFF8 | E_W'($urandom_range(0, 7));
			default: return E_W'($urandom_range(0, 4095));
		endcase
	endfunction

	// One layer of n hits, clustered in a 4x4 patch or spread, with stray layer numbers.
	task automatic send_layer(int n, bit clustered);
		int bx, by;
		logic [L_W-1:0] lay, l;
		logic [X_W-1:0] x;
		logic [Y_W-1:0] y;
		bx = $urandom_range(0, 1023);
		by = $urandom_range(0, 1023);
		lay = L_W'($urandom_range(1, NUM_LAYERS));
		for (int i = 0; i < n; i++) begin
			x = clustered ? X_W'(bx + $urandom_range(0, 3)) : X_W'($urandom_range(0, 1023));
			y = clustered ? Y_W'(by + $urandom_range(0, 3)) : Y_W'($urandom_range(0, 1023));
			l = ($urandom_range(0, 11) == 0) ? L_W'($urandom_range(0, 127)) : lay;
			send_hit(x, y, pick_energy(), l, i == n - 1);
		end
	endtask

	// ---------------- tests ----------------

	task automatic test_directed();
		// ratio is 0 after reset: every hit is a candidate
		send_hit(10'd0, 10'd0, 24'd0, 7'd1, 1'b1);                   // zero corner, one hit
		send_hit(10'd1023, 10'd1023, 24'hFFFFFF, 7'd64, 1'b1);       // top corner, top layer
		send_hit(10'd5, 10'd5, 24'd9, 7'd0, 1'b1);                   // layer 0 only: none found
		send_hit(10'd5, 10'd5, 24'd9, 7'd65, 1'b0);                  // layers beyond range
		send_hit(10'd5, 10'd5, 24'd9, 7'd127, 1'b1);
		// veto chain on a diagonal; the middle hit loses to both neighbors
		send_hit(10'd5, 10'd5, 24'd100, 7'd7, 1'b0);
		send_hit(10'd6, 10'd6, 24'd50, 7'd7, 1'b0);
		send_hit(10'd7, 10'd7, 24'd200, 7'd7, 1'b0);
		send_hit(10'd8, 10'd5, 24'd100, 7'd7, 1'b1);                 // tie with first, load order
		// same cell never vetoes; x=0 and x=1023 are not neighbors
		send_hit(10'd3, 10'd3, 24'd40, 7'd33, 1'b0);
		send_hit(10'd3, 10'd3, 24'd80, 7'd33, 1'b0);
		send_hit(10'd0, 10'd700, 24'd10, 7'd33, 1'b0);
		send_hit(10'd1023, 10'd700, 24'd90, 7'd33, 1'b0);
		send_hit(10'd4, 10'd3, 24'd80, 7'd33, 1'b1);                 // equal energy: no veto
		// ratio of exactly one: only peak hits survive the cut
		write_ratio(RATIO_W'(RATIO_ONE));
		send_hit(10'd20, 10'd20, 24'd500, 7'd2, 1'b0);
		send_hit(10'd40, 10'd40, 24'd499, 7'd2, 1'b0);
		send_hit(10'd60, 10'd60, 24'd500, 7'd2, 1'b1);
		// ratio above one: nothing passes unless the peak is zero
		write_ratio(RATIO_W'(RATIO_MAX));
		send_hit(10'd20, 10'd20, 24'd500, 7'd3, 1'b1);
		send_hit(10'd21, 10'd20, 24'd0, 7'd3, 1'b1);
		write_ratio(RATIO_W'(RATIO_ONE + 1));
		send_hit(10'd22, 10'd20, 24'd0, 7'd4, 1'b0);
		send_hit(10'd23, 10'd20, 24'd1, 7'd4, 1'b1);
		stop_sending();
	endtask

	// Fill the store, then two more hits; the very last one still closes the layer.
	task automatic test_store_full();
		write_ratio(RATIO_W'(0));
		for (int i = 0; i < MAX_HITS + 2; i++)
			send_hit(X_W'(2 * i), Y_W'(3 * i), E_W'($urandom), 7'd12, i == MAX_HITS + 1);
		stop_sending();
	endtask

	task automatic test_random();
		int n;
		int start;
		start = hits_sent;
		while (hits_sent - start < 150) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 4))
					0: write_ratio(RATIO_W'(0));
					1: write_ratio(RATIO_W'(RATIO_ONE));
					2: write_ratio(RATIO_W'(RATIO_MAX));
					default: write_ratio(RATIO_W'($urandom_range(0, RATIO_ONE)));
				endcase
			end
			// stretches with no idling on either side
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en = ($urandom_range(0, 3) != 0);
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
			send_layer(n, $urandom_range(0, 4) != 0);
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		stop_sending();
	endtask

	// Output held off while new layers keep coming, so the input stalls.
	task automatic test_backpressure();
		write_ratio(RATIO_W'(0));
		rx_hold = 1'b1;
		hold_go = 1'b1;
		tx_idle_en = 1'b0;
		for (int i = 0; i < 4; i++)
			send_layer(16, 1'b0);
		tx_idle_en = 1'b1;
		stop_sending();
	endtask

	// ---------------- processes ----------------

	// receiver: random stall before each beat when enabled
	initial begin
		int gap;
		forever begin
			gap = rx_idle_en ? $urandom_range(0, 4) : 0;
			if (gap > 0) begin
				rx_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			rx_ready = 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			@(negedge clk);
		end
	end

	// long output hold, counted here once the test raises it
	initial begin
		wait (hold_go);
		repeat (HOLD_CYCLES) @(negedge clk);
		rx_hold = 1'b0;
	end

	// compare each output beat with the oldest expected seed
	always @(posedge clk) begin
		seed_beat_t w;
		if (m_axis_tvalid && m_axis_tready) begin
			if (seeds_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none actual data %h user %b last %b",
				         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end else begin
				w = seeds_due.pop_front();
				beats_checked++;
				if (m_axis_tdata[9:0] !== w.x) begin
					errors++;
					$display("%0t: seed_x expected %0d actual %0d", $time, w.x, m_axis_tdata[9:0]);
				end
				if (m_axis_tdata[19:10] !== w.y) begin
					errors++;
					$display("%0t: seed_y expected %0d actual %0d", $time, w.y,
					         m_axis_tdata[19:10]);
				end
				if (m_axis_tdata[43:20] !== w.e) begin
					errors++;
					$display("%0t: seed_energy expected %h actual %h", $time, w.e,
					         m_axis_tdata[43:20]);
				end
				if (m_axis_tdata[50:44] !== w.layer) begin
					errors++;
					$display("%0t: seed_layer expected %0d actual %0d", $time, w.layer,
					         m_axis_tdata[50:44]);
				end
				if (m_axis_tdata[55:51] !== 5'b0) begin
					errors++;
					$display("%0t: pad bits expected 0 actual %b", $time, m_axis_tdata[55:51]);
				end
				if (m_axis_tuser !== w.none) begin
					errors++;
					$display("%0t: none_found expected %b actual %b", $time, w.none, m_axis_tuser);
				end
				if (m_axis_tlast !== w.last) begin
					errors++;
					$display("%0t: last_seed expected %b actual %b", $time, w.last, m_axis_tlast);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycles, seeds_due.size());
			$display("calorimeter_layer_seed_finder_tb: done, errors");
			$finish;
		end
	end

	initial begin
		layer_peak = '0;
		layer_sel = '0;
		ratio_q = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_store_full();
		test_random();
		test_backpressure();
		wait (seeds_due.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("covered %0d hits in %0d layers, %0d output beats checked (%0d empty layers)",
		         hits_sent, layers_closed, beats_checked, empty_layers);
		$display("ratios 0, one, above one and random; long output hold with input stalled");
		if (errors == 0 && seeds_due.size() == 0)
			$display("calorimeter_layer_seed_finder_tb: done, clean");
		else
			$display("calorimeter_layer_seed_finder_tb: done, errors");
		$finish;
	end

endmodule
